### hw/rtl/rwf_pkg.sv
package rwf_pkg;

	// window centers and half width, binary angle units
	localparam logic [15:0] FRONT_CENTER       = 16'd0;
	localparam logic [15:0] FRONT_RIGHT_CENTER = 16'd57344;
	localparam logic [15:0] RIGHT_CENTER       = 16'd49152;
	localparam logic [15:0] WINDOW_HALF        = 16'd2731;

	localparam logic [15:0] NONE_MM      = 16'hFFFF;
	localparam logic [15:0] VALID_MIN_MM = 16'd20;

	// x / 10 == (x * RECIP10) >> RECIP10_SHIFT for x below 2^20
	localparam logic [19:0] RECIP10       = 20'd838861;
	localparam int          RECIP10_SHIFT = 23;

	localparam int QUEUE_DEPTH_DEF = 2;

	// navigation modes
	localparam logic [1:0] MODE_FOLLOW = 2'd0;
	localparam logic [1:0] MODE_TURN   = 2'd1;
	localparam logic [1:0] MODE_ADJUST = 2'd2;

	// register indexes
	localparam logic [2:0] REG_FRONT_STOP  = 3'd0;
	localparam logic [2:0] REG_LOST_WALL   = 3'd1;
	localparam logic [2:0] REG_DESIRED     = 3'd2;
	localparam logic [2:0] REG_GAIN        = 3'd3;
	localparam logic [2:0] REG_MAX_TURN    = 3'd4;
	localparam logic [2:0] REG_CRUISE      = 3'd5;
	localparam logic [2:0] REG_ANGLE_START = 3'd6;
	localparam logic [2:0] REG_ANGLE_STEP  = 3'd7;

	typedef struct packed {
		logic [15:0] front_stop_mm;
		logic [15:0] lost_wall_mm;
		logic [15:0] desired_wall_mm;
		logic [15:0] gain_q8;
		logic [14:0] max_turn_mrad_s;
		logic [14:0] cruise_mm_s;
		logic [15:0] angle_start;
		logic [15:0] angle_step;
	} cfg_t;

	// window minima of one finished scan
	typedef struct packed {
		logic [15:0] front_mm;
		logic [15:0] front_right_mm;
		logic [15:0] right_mm;
	} scan_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

### hw/rtl/rwf_front.sv
module rwf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  rwf_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [15:0]   range_mm,
	input  logic          last_ray,
	input  logic          q_full,
	output logic          push,
	output rwf_pkg::scan_t push_data
);
	import rwf_pkg::*;

	logic [15:0] ray_angle_q;
	logic [15:0] front_min_q;
	logic [15:0] front_right_min_q;
	logic [15:0] right_min_q;
	logic        take;
	logic        usable;
	scan_t       next_min;

	function automatic logic in_window(input logic [15:0] ang, input logic [15:0] center);
		logic [15:0] d;
		logic [15:0] mag;
		d   = ang - center;
		mag = d[15] ? (~d + 16'd1) : d;
		return mag <= WINDOW_HALF;
	endfunction

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign usable   = (cfg.angle_step != 16'd0) && (range_mm > VALID_MIN_MM);

	always_comb begin
		next_min.front_mm = front_min_q;
		next_min.front_right_mm = front_right_min_q;
		next_min.right_mm = right_min_q;
		if (usable && in_window(ray_angle_q, FRONT_CENTER) && range_mm < front_min_q) begin
			next_min.front_mm = range_mm;
		end
		if (usable && in_window(ray_angle_q, FRONT_RIGHT_CENTER)
				&& range_mm < front_right_min_q) begin
			next_min.front_right_mm = range_mm;
		end
		if (usable && in_window(ray_angle_q, RIGHT_CENTER) && range_mm < right_min_q) begin
			next_min.right_mm = range_mm;
		end
	end

	assign push      = take && last_ray;
	assign push_data = next_min;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_angle_q       <= 16'd0;
			front_min_q       <= NONE_MM;
			front_right_min_q <= NONE_MM;
			right_min_q       <= NONE_MM;
		end else if (take) begin
			if (last_ray) begin
				// scan done: restart minima and angle
				ray_angle_q       <= cfg.angle_start;
				front_min_q       <= NONE_MM;
				front_right_min_q <= NONE_MM;
				right_min_q       <= NONE_MM;
			end else begin
				ray_angle_q       <= ray_angle_q + cfg.angle_step;
				front_min_q       <= next_min.front_mm;
				front_right_min_q <= next_min.front_right_mm;
				right_min_q       <= next_min.right_mm;
			end
		end
	end

endmodule

### hw/rtl/rwf_queue.sv
module rwf_queue #(
	parameter int DEPTH = rwf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rwf_pkg::scan_t  push_data,
	input  logic            pop,
	output rwf_pkg::scan_t  head,
	output rwf_pkg::q_stat_t stat
);
	import rwf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	scan_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.empty = (count_q == CW'(0));
	assign stat.full  = (count_q == CW'(DEPTH));
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty))
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

### hw/rtl/rwf_back.sv
module rwf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rwf_pkg::cfg_t    cfg,
	input  rwf_pkg::scan_t   head,
	input  rwf_pkg::q_stat_t stat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [14:0]      linear_mm_s,
	output logic signed [15:0] angular_mrad_s,
	output logic [1:0]       nav_mode,
	output logic [15:0]      front_mm,
	output logic [15:0]      front_right_mm,
	output logic [15:0]      right_mm,
	output logic             command_valid
);
	import rwf_pkg::*;

	logic adv;

	// stage 1: flags and mode update
	logic        f_some, r_some, f_close, f_clear, r_lost, r_near_lost, r_at_wall;
	logic [1:0]  mode_q;
	logic [1:0]  mode_next;
	logic [18:0] num;
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic        cmd_s1;
	logic        r_some_s1;
	logic        f_close_s1;
	logic [18:0] num_s1;
	logic signed [16:0] diff_s1;
	scan_t       scan_s1;

	// stage 2: products
	logic [38:0]        quot_prod;
	logic signed [33:0] p_prod;
	logic        valid_s2;
	logic [1:0]  mode_s2;
	logic        cmd_s2;
	logic        r_some_s2;
	logic        f_close_s2;
	logic [14:0] quot_s2;
	logic signed [33:0] p_s2;
	scan_t       scan_s2;

	// stage 3: rounding, clamp and selection
	logic        p_neg;
	logic [33:0] p_abs;
	logic [33:0] rnd_sum;
	logic [25:0] rnd;
	logic [14:0] mag;
	logic [14:0] half;
	logic [14:0] lin;
	logic signed [15:0] ang;

	logic        out_valid_q;
	logic [14:0] lin_q;
	logic signed [15:0] ang_q;
	logic [1:0]  mode_out_q;
	scan_t       scan_q;
	logic        cmd_q;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !stat.empty;

	always_comb begin
		f_some      = head.front_mm != NONE_MM;
		r_some      = head.right_mm != NONE_MM;
		f_close     = f_some && (head.front_mm < cfg.front_stop_mm);
		f_clear     = !f_some || ((19'(head.front_mm) * 19'd5) >= (19'(cfg.front_stop_mm) * 19'd6));
		r_lost      = !r_some || (head.right_mm > cfg.lost_wall_mm);
		r_near_lost = r_some && (head.right_mm < cfg.lost_wall_mm);
		r_at_wall   = r_some && ((19'(head.right_mm) * 19'd5) <= (19'(cfg.desired_wall_mm) * 19'd6));
		mode_next   = mode_q;
		unique case (mode_q)
			MODE_TURN: begin
				if (f_clear && r_near_lost) mode_next = MODE_FOLLOW;
			end
			MODE_ADJUST: begin
				if (r_at_wall) mode_next = MODE_FOLLOW;
				else if (f_close) mode_next = MODE_TURN;
			end
			default: begin
				// follow, and the unused code behaves as follow
				if (f_close) mode_next = MODE_TURN;
				else if (r_lost) mode_next = MODE_ADJUST;
				else mode_next = MODE_FOLLOW;
			end
		endcase
		// the one product by 0.9, 0.8 or 0.6 this result needs, before the divide by ten
		if (mode_next == MODE_TURN) begin
			num = 19'(cfg.max_turn_mrad_s) * 19'd9 + 19'd5;
		end else if (f_close) begin
			num = 19'(cfg.max_turn_mrad_s) * 19'd8 + 19'd5;
		end else begin
			num = 19'(cfg.cruise_mm_s) * 19'd6 + 19'd5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FOLLOW;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			if (pop) begin
				mode_q <= mode_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1    <= mode_next;
			cmd_s1     <= f_some || r_some;
			r_some_s1  <= r_some;
			f_close_s1 <= f_close;
			num_s1     <= num;
			diff_s1    <= $signed({1'b0, cfg.desired_wall_mm}) - $signed({1'b0, head.right_mm});
			scan_s1    <= head;
		end
	end

	assign quot_prod = 39'(num_s1) * 39'(RECIP10);
	assign p_prod    = $signed({1'b0, cfg.gain_q8}) * diff_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2    <= mode_s1;
			cmd_s2     <= cmd_s1;
			r_some_s2  <= r_some_s1;
			f_close_s2 <= f_close_s1;
			quot_s2    <= quot_prod[RECIP10_SHIFT +: 15];
			p_s2       <= p_prod;
			scan_s2    <= scan_s1;
		end
	end

	always_comb begin
		p_neg   = p_s2[33];
		p_abs   = p_neg ? 34'(-p_s2) : 34'(p_s2);
		rnd_sum = p_abs + 34'd128;
		rnd     = rnd_sum[33:8];
		mag     = (rnd > 26'(cfg.max_turn_mrad_s)) ? cfg.max_turn_mrad_s : rnd[14:0];
		half    = 15'((16'(cfg.max_turn_mrad_s) + 16'd1) >> 1);
		lin     = '0;
		ang     = '0;
		if (cmd_s2) begin
			unique case (mode_s2)
				MODE_TURN: begin
					ang = $signed({1'b0, quot_s2});
				end
				MODE_ADJUST: begin
					if (f_close_s2) begin
						ang = $signed({1'b0, quot_s2});
					end else begin
						lin = quot_s2;
						ang = -$signed({1'b0, half});
					end
				end
				default: begin
					lin = cfg.cruise_mm_s;
					if (!r_some_s2) begin
						ang = -$signed({1'b0, cfg.max_turn_mrad_s});
					end else if (p_neg) begin
						ang = -$signed({1'b0, mag});
					end else begin
						ang = $signed({1'b0, mag});
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lin_q      <= lin;
			ang_q      <= ang;
			mode_out_q <= mode_s2;
			scan_q     <= scan_s2;
			cmd_q      <= cmd_s2;
		end
	end

	assign out_valid      = out_valid_q;
	assign linear_mm_s    = lin_q;
	assign angular_mrad_s = ang_q;
	assign nav_mode       = mode_out_q;
	assign front_mm       = scan_q.front_mm;
	assign front_right_mm = scan_q.front_right_mm;
	assign right_mm       = scan_q.right_mm;
	assign command_valid  = cmd_q;

`ifndef SYNTHESIS
	a_idle_cmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !cmd_q) |-> (lin_q == 15'd0 && ang_q == 16'sd0))
		else $error("speeds not zero on an empty scan");
	a_turn_stands: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && mode_out_q == MODE_TURN) |-> (lin_q == 15'd0))
		else $error("forward speed while turning a corner");
	a_empty_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && scan_q.front_mm == NONE_MM && scan_q.right_mm == NONE_MM)
		|-> !cmd_q)
		else $error("command flagged valid with no front and no right reading");
`endif

endmodule

### hw/rtl/lidar_right_wall_follower.sv
// right-hand wall follower fed by a stream of lidar rays
//
// input channel: in_valid / in_ready with range_mm and last_ray, one ray per
// transfer; up to one ray is taken every cycle. each ray gets the next angle
// from angle_start in steps of angle_step (the first scan after reset starts at zero),
// and folds into the front, front-right and right window minima as it arrives.
// output channel: out_valid / out_ready; one command per scan, on the ray
// marked last_ray: speeds, mode after the update and the three minima.
// path: the command reaches out_valid from the last ray's transfer through the
// queue, the flag/mode stage, the product stage and the output register.
// throughput: one ray per cycle while the queue is not full; the back handles
// one finished scan per cycle while out_ready does not stall it.
// a small queue of finished scans sits between front and back. when the
// receiver stalls, the back holds its result and the queue fills; in_ready
// drops only while the queue is full.
// config: cfg_we / cfg_index / cfg_wdata, one register per write, no wait.
// reset: registers take their default values, the mode goes to follow, the
// minima go to none and the ray angle to zero.
module lidar_right_wall_follower #(
	parameter int QUEUE_DEPTH = rwf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        range_mm,
	input  logic               last_ray,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [14:0]        linear_mm_s,
	output logic signed [15:0] angular_mrad_s,
	output logic [1:0]         nav_mode,
	output logic [15:0]        front_mm,
	output logic [15:0]        front_right_mm,
	output logic [15:0]        right_mm,
	output logic               command_valid
);
	import rwf_pkg::*;

	cfg_t    cfg_q;
	logic    push;
	scan_t   push_data;
	logic    pop;
	scan_t   head;
	q_stat_t stat;

	// configuration registers: the user writes only while the block is idle; not enforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.front_stop_mm   <= 16'd400;
			cfg_q.lost_wall_mm    <= 16'd800;
			cfg_q.desired_wall_mm <= 16'd400;
			cfg_q.gain_q8         <= 16'd256;
			cfg_q.max_turn_mrad_s <= 15'd1000;
			cfg_q.cruise_mm_s     <= 15'd200;
			cfg_q.angle_start     <= 16'd0;
			cfg_q.angle_step      <= 16'd182;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRONT_STOP:  cfg_q.front_stop_mm   <= cfg_wdata;
				REG_LOST_WALL:   cfg_q.lost_wall_mm    <= cfg_wdata;
				REG_DESIRED:     cfg_q.desired_wall_mm <= cfg_wdata;
				REG_GAIN:        cfg_q.gain_q8         <= cfg_wdata;
				REG_MAX_TURN:    cfg_q.max_turn_mrad_s <= cfg_wdata[14:0];
				REG_CRUISE:      cfg_q.cruise_mm_s     <= cfg_wdata[14:0];
				REG_ANGLE_START: cfg_q.angle_start     <= cfg_wdata;
				REG_ANGLE_STEP:  cfg_q.angle_step      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front: ray angle and window minima, pushes one summary per scan
	rwf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.range_mm  (range_mm),
		.last_ray  (last_ray),
		.q_full    (stat.full),
		.push      (push),
		.push_data (push_data)
	);

	// finished scans waiting for the back
	rwf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	// back: mode machine and speed command
	rwf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head           (head),
		.stat           (stat),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.linear_mm_s    (linear_mm_s),
		.angular_mrad_s (angular_mrad_s),
		.nav_mode       (nav_mode),
		.front_mm       (front_mm),
		.front_right_mm (front_right_mm),
		.right_mm       (right_mm),
		.command_valid  (command_valid)
	);

endmodule
